// ===== design/dpnm_pkg.sv =====
package dpnm_pkg;

  localparam int unsigned NumPads  = 32;
  localparam int unsigned PadLow   = 68;
  localparam int unsigned PadHigh  = PadLow + NumPads - 1;
  localparam int unsigned GridCols = 8;
  localparam int unsigned IdxW     = $clog2(NumPads);
  localparam int unsigned ColW     = $clog2(GridCols);
  localparam int unsigned RowW     = IdxW - ColW;

  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 32;

  localparam int unsigned EvtDepth = 4;
  localparam int unsigned EvtPtrW  = $clog2(EvtDepth);
  localparam int unsigned EvtCntW  = $clog2(EvtDepth + 1);

  localparam logic [7:0] StatusNoteOff  = 8'h80;
  localparam logic [7:0] StatusNoteOn   = 8'h90;
  localparam logic [7:0] StatusPressure = 8'hA0;
  localparam logic [3:0] CinNoteOn      = 4'h9;
  localparam logic [3:0] CinNoteOff     = 4'h8;
  localparam logic [6:0] FixedVelocity  = 7'd100;
  localparam logic [6:0] VelocityMax    = 7'd127;
  localparam logic [6:0] BaseNoteMax    = 7'd96;
  localparam logic [6:0] BaseNoteReset  = 7'd36;

  typedef enum logic [1:0] {
    EvNone     = 2'd0,
    EvNote     = 2'd1,
    EvRatStart = 2'd2,
    EvRatVel   = 2'd3
  } event_kind_e;

  typedef enum logic [1:0] {
    ModeDrums    = 2'd0,
    ModeVelocity = 2'd1,
    ModeRatchet  = 2'd2
  } pad_mode_e;

  typedef enum logic [1:0] {
    RegPadMode  = 2'd0,
    RegBaseNote = 2'd1,
    RegFixedVel = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic       req_type;
    logic [3:0] cable_num;
    logic [7:0] status_byte;
    logic [6:0] note_in;
    logic [6:0] value_in;
    logic [3:0] track_channel;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic       handled_flag;
    logic [3:0] code_index;
    logic [7:0] status_out;
    logic [6:0] note_out;
    logic [6:0] velocity_out;
    logic [1:0] ratchet_rate_sel;
    logic [1:0] ratchet_pattern_sel;
    logic       last_result;
  } out_item_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } fifo_push_t;

endpackage

// ===== design/dpnm_in_if.sv =====
interface dpnm_in_if;
  logic                valid;
  logic                ready;
  dpnm_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/dpnm_out_if.sv =====
interface dpnm_out_if;
  logic                valid;
  logic                ready;
  dpnm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/dpnm_evt_fifo.sv =====
module dpnm_evt_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dpnm_pkg::fifo_push_t push_i,
  input  dpnm_pkg::out_item_t  data0_i,
  input  dpnm_pkg::out_item_t  data1_i,
  output logic                 room_o,
  dpnm_out_if.source           evt_o
);

  dpnm_pkg::out_item_t                  mem_q [dpnm_pkg::EvtDepth];
  logic [dpnm_pkg::EvtPtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [dpnm_pkg::EvtPtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [dpnm_pkg::EvtCntW-1:0]         count_q, count_d;
  logic                                 pop;

  assign pop         = evt_o.valid && evt_o.ready;
  assign evt_o.valid = (count_q != '0);
  assign evt_o.data  = mem_q[rd_ptr_q];
  assign room_o      = (count_q <= dpnm_pkg::EvtCntW'(dpnm_pkg::EvtDepth - 2));

  always_comb begin
    rd_ptr_d = rd_ptr_q + dpnm_pkg::EvtPtrW'(pop);
    wr_ptr_d = wr_ptr_q + dpnm_pkg::EvtPtrW'(push_i.push0) + dpnm_pkg::EvtPtrW'(push_i.push1);
    count_d  = count_q + dpnm_pkg::EvtCntW'(push_i.push0) + dpnm_pkg::EvtCntW'(push_i.push1)
               - dpnm_pkg::EvtCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push_i.push1) begin
      mem_q[wr_ptr_q + dpnm_pkg::EvtPtrW'(1)] <= data1_i;
    end
  end

endmodule

// ===== design/drum_pad_note_mapper.sv =====
// Drum pad note mapper. Each input transaction is registered, mapped in the
// following cycle and its one or two result transactions are pushed into a
// four-entry result queue, so a new input is taken every cycle while the sink
// keeps up, and a ratchet restart yields two results back to back. The input
// stalls only when the result queue has fewer than two free entries. Pad held
// state (note and channel per pad) lives in flops indexed by the pad; an
// all-notes-off request releases every pad at once. Registers on the APB port
// (mode at 0x0, root note at 0x4, fixed velocity at 0x8) must only be written
// while no transaction is in flight; writing the root note also resets the
// most recent note.
module drum_pad_note_mapper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dpnm_in_if.sink                       pkt_i,
  dpnm_out_if.source                    evt_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dpnm_pkg::PaddrW-1:0]   paddr,
  input  logic [dpnm_pkg::PdataW-1:0]   pwdata,
  output logic [dpnm_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned IdxW = dpnm_pkg::IdxW;
  localparam int unsigned ColW = dpnm_pkg::ColW;
  localparam int unsigned RowW = dpnm_pkg::RowW;

  function automatic dpnm_pkg::out_item_t mk_evt(
    input dpnm_pkg::event_kind_e kind,
    input logic                  handled,
    input logic                  on,
    input logic [3:0]            chan,
    input logic [6:0]            note,
    input logic [6:0]            vel,
    input logic [1:0]            rate,
    input logic [1:0]            pat,
    input logic                  last
  );
    dpnm_pkg::out_item_t e;
    logic                active;
    active                = (kind != dpnm_pkg::EvNone);
    e.event_kind          = kind;
    e.handled_flag        = handled;
    e.code_index          = active ? (on ? dpnm_pkg::CinNoteOn : dpnm_pkg::CinNoteOff) : 4'h0;
    e.status_out          = active ? ((on ? dpnm_pkg::StatusNoteOn : dpnm_pkg::StatusNoteOff)
                                      | {4'h0, chan}) : 8'h00;
    e.note_out            = active ? note : 7'd0;
    e.velocity_out        = active ? vel : 7'd0;
    e.ratchet_rate_sel    = rate;
    e.ratchet_pattern_sel = pat;
    e.last_result         = last;
    return e;
  endfunction

  function automatic dpnm_pkg::out_item_t none_evt(input logic handled);
    return mk_evt(dpnm_pkg::EvNone, handled, 1'b0, 4'h0, 7'd0, 7'd0, 2'd0, 2'd0, 1'b1);
  endfunction

  // configuration
  dpnm_pkg::pad_mode_e   pad_mode_q;
  logic [6:0]            root_note_q;
  logic                  fixed_vel_q;
  logic                  cfg_wr;
  dpnm_pkg::cfg_reg_e    cfg_sel;
  logic [6:0]            base_wr;

  // input stage
  logic                  s1_valid_q;
  dpnm_pkg::in_item_t    s1_q;
  logic                  fire;
  logic                  fifo_room;

  // mapper state
  logic [dpnm_pkg::NumPads-1:0] pad_held_q;
  logic [6:0]            pad_note_q [dpnm_pkg::NumPads];
  logic [3:0]            held_chan_q [dpnm_pkg::NumPads];
  logic [6:0]            recent_q, recent_d;
  logic                  rat_active_q, rat_active_d;
  logic [IdxW-1:0]       rat_pad_q, rat_pad_d;
  logic [6:0]            rat_note_q, rat_note_d;
  logic [6:0]            rat_vel_q, rat_vel_d;
  logic [3:0]            rat_chan_q, rat_chan_d;
  logic [1:0]            rat_rate_q, rat_rate_d;
  logic [1:0]            rat_pat_q, rat_pat_d;
  logic                  held_clr_all, held_set, held_clr;

  // decode
  logic                  pad_hit, type_ok, is_press, is_on;
  logic [7:0]            stype;
  logic [IdxW-1:0]       idx;
  logic [RowW-1:0]       row;
  logic [ColW-1:0]       col;
  logic [3:0]            ridx;
  logic [7:0]            right_vel8;
  logic [6:0]            right_vel;
  logic [6:0]            pad_vel;
  logic [7:0]            note_sum;
  logic                  rat_match;

  dpnm_pkg::out_item_t   ev0, ev1, rat_start;
  dpnm_pkg::fifo_push_t  push;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = dpnm_pkg::cfg_reg_e'(paddr[3:2]);
  assign base_wr = (pwdata[6:0] > dpnm_pkg::BaseNoteMax) ? dpnm_pkg::BaseNoteMax : pwdata[6:0];

  always_comb begin
    case (cfg_sel)
      dpnm_pkg::RegPadMode:  prdata = {{(dpnm_pkg::PdataW-2){1'b0}}, pad_mode_q};
      dpnm_pkg::RegBaseNote: prdata = {{(dpnm_pkg::PdataW-7){1'b0}}, root_note_q};
      dpnm_pkg::RegFixedVel: prdata = {{(dpnm_pkg::PdataW-1){1'b0}}, fixed_vel_q};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_mode_q  <= dpnm_pkg::ModeDrums;
      root_note_q <= dpnm_pkg::BaseNoteReset;
      fixed_vel_q <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        dpnm_pkg::RegPadMode: begin
          pad_mode_q <= (pwdata[1:0] == 2'd3) ? dpnm_pkg::ModeDrums
                                              : dpnm_pkg::pad_mode_e'(pwdata[1:0]);
        end
        dpnm_pkg::RegBaseNote: root_note_q <= base_wr;
        dpnm_pkg::RegFixedVel: fixed_vel_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // ---------------- input register ----------------
  assign fire        = s1_valid_q && fifo_room;
  assign pkt_i.ready = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pkt_i.ready) begin
      s1_valid_q <= pkt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_i.valid && pkt_i.ready) begin
      s1_q <= pkt_i.data;
    end
  end

  // ---------------- mapping ----------------
  always_comb begin
    stype     = s1_q.status_byte & 8'hF0;
    pad_hit   = (s1_q.cable_num == 4'h0)
                && ({1'b0, s1_q.note_in} >= 8'(dpnm_pkg::PadLow))
                && ({1'b0, s1_q.note_in} <= 8'(dpnm_pkg::PadHigh));
    type_ok   = (stype == dpnm_pkg::StatusNoteOff) || (stype == dpnm_pkg::StatusNoteOn)
                || (stype == dpnm_pkg::StatusPressure);
    is_press  = (stype == dpnm_pkg::StatusPressure);
    is_on     = (stype == dpnm_pkg::StatusNoteOn) && (s1_q.value_in != 7'd0);
    idx       = IdxW'(s1_q.note_in - 7'(dpnm_pkg::PadLow));
    col       = idx[ColW-1:0];
    row       = idx[IdxW-1:ColW];
    // right half pad index: row*4 + (col-4)
    ridx      = {row[1:0], col[1:0]};
    right_vel8 = ({4'h0, ridx} + 8'd1) << 3;
    right_vel = fixed_vel_q ? dpnm_pkg::FixedVelocity
                : ((right_vel8 > 8'd127) ? dpnm_pkg::VelocityMax : right_vel8[6:0]);
    pad_vel   = fixed_vel_q ? dpnm_pkg::FixedVelocity : s1_q.value_in;
    note_sum  = (pad_mode_q == dpnm_pkg::ModeDrums)
                ? ({1'b0, root_note_q} + 8'(idx))
                : ({1'b0, root_note_q} + {4'h0, ridx});
    rat_match = (pad_mode_q == dpnm_pkg::ModeRatchet) && rat_active_q && (rat_pad_q == idx);

    rat_active_d = rat_active_q;
    rat_pad_d    = rat_pad_q;
    rat_note_d   = rat_note_q;
    rat_vel_d    = rat_vel_q;
    rat_chan_d   = rat_chan_q;
    rat_rate_d   = rat_rate_q;
    rat_pat_d    = rat_pat_q;
    recent_d     = recent_q;
    held_clr_all = 1'b0;
    held_set     = 1'b0;
    held_clr     = 1'b0;
    ev0          = none_evt(1'b1);
    ev1          = none_evt(1'b1);
    push.push0   = fire;
    push.push1   = 1'b0;
    rat_start    = mk_evt(dpnm_pkg::EvRatStart, 1'b1, 1'b1, s1_q.track_channel, recent_q,
                          pad_vel, col[1:0], row[1:0], 1'b1);

    if (s1_q.req_type) begin
      ev0 = none_evt(1'b0);
      if (rat_active_q) begin
        ev0 = mk_evt(dpnm_pkg::EvNote, 1'b0, 1'b0, rat_chan_q, rat_note_q, 7'd0,
                     2'd0, 2'd0, 1'b1);
        rat_active_d = 1'b0;
      end
      held_clr_all = 1'b1;
    end else if (!pad_hit || !type_ok) begin
      ev0 = none_evt(1'b0);
    end else if (is_press) begin
      if (rat_match) begin
        rat_vel_d = (s1_q.value_in == 7'd0) ? 7'd1 : s1_q.value_in;
        ev0 = mk_evt(dpnm_pkg::EvRatVel, 1'b1, 1'b1, rat_chan_q, rat_note_q, rat_vel_d,
                     rat_rate_q, rat_pat_q, 1'b1);
      end
    end else if ((pad_mode_q != dpnm_pkg::ModeDrums) && col[ColW-1]) begin
      if (is_on) begin
        if (pad_mode_q == dpnm_pkg::ModeVelocity) begin
          ev0 = mk_evt(dpnm_pkg::EvNote, 1'b1, 1'b1, s1_q.track_channel, recent_q,
                       right_vel, 2'd0, 2'd0, 1'b1);
        end else begin
          rat_active_d = 1'b1;
          rat_pad_d    = idx;
          rat_note_d   = recent_q;
          rat_vel_d    = pad_vel;
          rat_chan_d   = s1_q.track_channel;
          rat_rate_d   = col[1:0];
          rat_pat_d    = row[1:0];
          if (rat_active_q) begin
            // restart: stop the old ratchet first
            ev0 = mk_evt(dpnm_pkg::EvNote, 1'b1, 1'b0, rat_chan_q, rat_note_q, 7'd0,
                         2'd0, 2'd0, 1'b0);
            ev1 = rat_start;
            push.push1 = fire;
          end else begin
            ev0 = rat_start;
          end
        end
      end else if (rat_match) begin
        ev0 = mk_evt(dpnm_pkg::EvNote, 1'b1, 1'b0, rat_chan_q, rat_note_q, 7'd0,
                     2'd0, 2'd0, 1'b1);
        rat_active_d = 1'b0;
      end
    end else if (is_on) begin
      if (note_sum <= 8'd127) begin
        ev0 = mk_evt(dpnm_pkg::EvNote, 1'b1, 1'b1, s1_q.track_channel, note_sum[6:0],
                     pad_vel, 2'd0, 2'd0, 1'b1);
        recent_d = note_sum[6:0];
        held_set = 1'b1;
      end
    end else if (pad_held_q[idx]) begin
      ev0 = mk_evt(dpnm_pkg::EvNote, 1'b1, 1'b0, held_chan_q[idx], pad_note_q[idx], 7'd0,
                   2'd0, 2'd0, 1'b1);
      held_clr = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_held_q   <= '0;
      recent_q     <= dpnm_pkg::BaseNoteReset;
      rat_active_q <= 1'b0;
      rat_pad_q    <= '0;
      rat_note_q   <= '0;
      rat_vel_q    <= '0;
      rat_chan_q   <= '0;
      rat_rate_q   <= '0;
      rat_pat_q    <= '0;
    end else if (cfg_wr && (cfg_sel == dpnm_pkg::RegBaseNote)) begin
      recent_q <= base_wr;
    end else if (fire) begin
      recent_q     <= recent_d;
      rat_active_q <= rat_active_d;
      rat_pad_q    <= rat_pad_d;
      rat_note_q   <= rat_note_d;
      rat_vel_q    <= rat_vel_d;
      rat_chan_q   <= rat_chan_d;
      rat_rate_q   <= rat_rate_d;
      rat_pat_q    <= rat_pat_d;
      if (held_clr_all) begin
        pad_held_q <= '0;
      end else if (held_set) begin
        pad_held_q[idx] <= 1'b1;
      end else if (held_clr) begin
        pad_held_q[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && held_set) begin
      pad_note_q[idx]  <= note_sum[6:0];
      held_chan_q[idx] <= s1_q.track_channel;
    end
  end

  dpnm_evt_fifo u_evt_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data0_i (ev0),
    .data1_i (ev1),
    .room_o  (fifo_room),
    .evt_o   (evt_o)
  );

  // two results only come from a ratchet restart
  a_two_needs_ratchet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push1 |-> (push.push0 && rat_active_q && pad_mode_q == dpnm_pkg::ModeRatchet))
    else $error("second result without an active ratchet");

  a_all_off_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_q.req_type) |=> (pad_held_q == '0 && !rat_active_q))
    else $error("all notes off left state behind");

  a_held_after_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && held_set && !cfg_wr) |=> pad_held_q[$past(idx)])
    else $error("note-on did not mark the pad held");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !fifo_room) |=> (s1_valid_q && $stable(s1_q)))
    else $error("pending transaction lost while result queue full");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 150;

  class pad_event_scoreboard;
    dpnm_pkg::pad_mode_e              mode;
    logic [6:0]                       root_note;
    bit                               fixed_vel;
    logic [dpnm_pkg::NumPads-1:0]     held;
    logic [6:0]                       pad_note [dpnm_pkg::NumPads];
    logic [3:0]                       held_chan [dpnm_pkg::NumPads];
    logic [6:0]                       recent_note;
    bit                               rat_on;
    logic [dpnm_pkg::IdxW-1:0]        rat_pad;
    logic [6:0]                       rat_note;
    logic [6:0]                       rat_vel;
    logic [3:0]                       rat_chan;
    logic [1:0]                       rat_rate;
    logic [1:0]                       rat_row;
    dpnm_pkg::out_item_t              pending_events [$];
    int                               errors;

    function new();
      mode        = dpnm_pkg::ModeDrums;
      root_note   = dpnm_pkg::BaseNoteReset;
      fixed_vel   = 1'b0;
      held        = '0;
      recent_note = dpnm_pkg::BaseNoteReset;
      rat_on      = 1'b0;
      rat_pad     = '0;
      rat_note    = '0;
      rat_vel     = '0;
      rat_chan    = '0;
      rat_rate    = '0;
      rat_row     = '0;
      errors      = 0;
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    function void set_register(dpnm_pkg::cfg_reg_e which, logic [31:0] value);
      case (which)
        dpnm_pkg::RegPadMode: begin
          mode = (value[1:0] == 2'd3) ? dpnm_pkg::ModeDrums
                                      : dpnm_pkg::pad_mode_e'(value[1:0]);
        end
        dpnm_pkg::RegBaseNote: begin
          root_note   = (value[6:0] > dpnm_pkg::BaseNoteMax) ? dpnm_pkg::BaseNoteMax
                                                              : value[6:0];
          recent_note = root_note;
        end
        dpnm_pkg::RegFixedVel: begin
          fixed_vel = value[0];
        end
        default: begin
        end
      endcase
    endfunction

    function dpnm_pkg::out_item_t make_evt(dpnm_pkg::event_kind_e kind, bit handled, bit on,
                                           logic [3:0] chan, logic [6:0] note,
                                           logic [6:0] vel, logic [1:0] rate,
                                           logic [1:0] row);
      dpnm_pkg::out_item_t r;
      r = '0;
      r.event_kind          = kind;
      r.handled_flag        = handled;
      r.ratchet_rate_sel    = rate;
      r.ratchet_pattern_sel = row;
      if (kind != dpnm_pkg::EvNone) begin
        r.code_index   = on ? dpnm_pkg::CinNoteOn : dpnm_pkg::CinNoteOff;
        r.status_out   = (on ? dpnm_pkg::StatusNoteOn : dpnm_pkg::StatusNoteOff) | {4'h0, chan};
        r.note_out     = note;
        r.velocity_out = vel;
      end
      return r;
    endfunction

    // Works out the events one accepted packet causes and queues them.
    function void map_packet(dpnm_pkg::in_item_t it);
      dpnm_pkg::out_item_t       res [$];
      dpnm_pkg::out_item_t       tail;
      logic [7:0]                kind_bits;
      logic [dpnm_pkg::IdxW-1:0] idx;
      logic [dpnm_pkg::RowW-1:0] row;
      logic [dpnm_pkg::ColW-1:0] col;
      int                        ridx;
      int                        vel;
      int                        note;
      bit                        on;

      kind_bits = it.status_byte & 8'hF0;
      idx       = dpnm_pkg::IdxW'(int'(it.note_in) - int'(dpnm_pkg::PadLow));
      row       = idx[dpnm_pkg::IdxW-1:dpnm_pkg::ColW];
      col       = idx[dpnm_pkg::ColW-1:0];
      on        = (kind_bits == dpnm_pkg::StatusNoteOn) && (it.value_in != 0);

      if (it.req_type) begin
        if (rat_on) begin
          res.push_back(make_evt(dpnm_pkg::EvNote, 1'b0, 1'b0, rat_chan, rat_note, '0, '0, '0));
          rat_on = 1'b0;
        end else begin
          res.push_back(make_evt(dpnm_pkg::EvNone, 1'b0, 1'b0, '0, '0, '0, '0, '0));
        end
        held = '0;
      end else if (it.cable_num != 0 || it.note_in < dpnm_pkg::PadLow ||
                   it.note_in > dpnm_pkg::PadHigh ||
                   !(kind_bits == dpnm_pkg::StatusNoteOff ||
                     kind_bits == dpnm_pkg::StatusNoteOn ||
                     kind_bits == dpnm_pkg::StatusPressure)) begin
        res.push_back(make_evt(dpnm_pkg::EvNone, 1'b0, 1'b0, '0, '0, '0, '0, '0));
      end else if (kind_bits == dpnm_pkg::StatusPressure) begin
        if (mode == dpnm_pkg::ModeRatchet && rat_on && rat_pad == idx) begin
          rat_vel = (it.value_in == 0) ? 7'd1 : it.value_in;
          res.push_back(make_evt(dpnm_pkg::EvRatVel, 1'b1, 1'b1, rat_chan, rat_note, rat_vel,
                                 rat_rate, rat_row));
        end else begin
          res.push_back(make_evt(dpnm_pkg::EvNone, 1'b1, 1'b0, '0, '0, '0, '0, '0));
        end
      end else if (mode != dpnm_pkg::ModeDrums && col[dpnm_pkg::ColW-1]) begin
        // right half of the grid: velocity or ratchet pads
        ridx = int'(row) * 4 + int'(col[1:0]);
        if (on && mode == dpnm_pkg::ModeVelocity) begin
          vel = (ridx + 1) * 8;
          if (vel > dpnm_pkg::VelocityMax) vel = dpnm_pkg::VelocityMax;
          if (fixed_vel) vel = dpnm_pkg::FixedVelocity;
          res.push_back(make_evt(dpnm_pkg::EvNote, 1'b1, 1'b1, it.track_channel, recent_note,
                                 7'(vel), '0, '0));
        end else if (on) begin
          if (rat_on)
            res.push_back(make_evt(dpnm_pkg::EvNote, 1'b1, 1'b0, rat_chan, rat_note, '0, '0,
                                   '0));
          rat_on   = 1'b1;
          rat_pad  = idx;
          rat_note = recent_note;
          rat_vel  = fixed_vel ? dpnm_pkg::FixedVelocity : it.value_in;
          rat_chan = it.track_channel;
          rat_rate = col[1:0];
          rat_row  = row;
          res.push_back(make_evt(dpnm_pkg::EvRatStart, 1'b1, 1'b1, rat_chan, rat_note, rat_vel,
                                 rat_rate, rat_row));
        end else if (mode == dpnm_pkg::ModeRatchet && rat_on && rat_pad == idx) begin
          res.push_back(make_evt(dpnm_pkg::EvNote, 1'b1, 1'b0, rat_chan, rat_note, '0, '0, '0));
          rat_on = 1'b0;
        end else begin
          res.push_back(make_evt(dpnm_pkg::EvNone, 1'b1, 1'b0, '0, '0, '0, '0, '0));
        end
      end else if (on) begin
        note = (mode == dpnm_pkg::ModeDrums) ? int'(root_note) + int'(idx)
                                             : int'(root_note) + int'(row) * 4 + int'(col);
        vel  = fixed_vel ? int'(dpnm_pkg::FixedVelocity) : int'(it.value_in);
        if (note > 127) begin
          res.push_back(make_evt(dpnm_pkg::EvNone, 1'b1, 1'b0, '0, '0, '0, '0, '0));
        end else begin
          res.push_back(make_evt(dpnm_pkg::EvNote, 1'b1, 1'b1, it.track_channel, 7'(note),
                                 7'(vel), '0, '0));
          recent_note    = 7'(note);
          pad_note[idx]  = 7'(note);
          held_chan[idx] = it.track_channel;
          held[idx]      = 1'b1;
        end
      end else if (!held[idx]) begin
        res.push_back(make_evt(dpnm_pkg::EvNone, 1'b1, 1'b0, '0, '0, '0, '0, '0));
      end else begin
        res.push_back(make_evt(dpnm_pkg::EvNote, 1'b1, 1'b0, held_chan[idx], pad_note[idx],
                               '0, '0, '0));
        held[idx] = 1'b0;
      end

      tail = res.pop_back();
      tail.last_result = 1'b1;
      res.push_back(tail);
      foreach (res[i]) pending_events.push_back(res[i]);
    endfunction

    function void field_check(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void compare_event(dpnm_pkg::out_item_t got);
      dpnm_pkg::out_item_t want;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      field_check("event_kind", want.event_kind, got.event_kind);
      field_check("handled_flag", want.handled_flag, got.handled_flag);
      field_check("code_index", want.code_index, got.code_index);
      field_check("status_out", want.status_out, got.status_out);
      field_check("note_out", want.note_out, got.note_out);
      field_check("velocity_out", want.velocity_out, got.velocity_out);
      field_check("ratchet_rate_sel", want.ratchet_rate_sel, got.ratchet_rate_sel);
      field_check("ratchet_pattern_sel", want.ratchet_pattern_sel, got.ratchet_pattern_sel);
      field_check("last_result", want.last_result, got.last_result);
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [dpnm_pkg::PaddrW-1:0] paddr;
  logic [dpnm_pkg::PdataW-1:0] pwdata;
  logic [dpnm_pkg::PdataW-1:0] prdata;
  logic                        pready;
  logic                        steady = 1'b0;
  int                          hold_reqs = 0;
  int                          holds_done = 0;
  logic [dpnm_pkg::IdxW-1:0]   recent_pads [4];
  int                          quiet_cycles = 0;

  pad_event_scoreboard sb = new();

  dpnm_in_if  pkt_if ();
  dpnm_out_if evt_if ();

  drum_pad_note_mapper uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .pkt_i   (pkt_if),
    .evt_o   (evt_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // result side checked first so an event can never match a packet taken on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (evt_if.valid && evt_if.ready) sb.compare_event(evt_if.data);
      if (pkt_if.valid && pkt_if.ready) sb.map_packet(pkt_if.data);
    end
  end

  always @(posedge clk) begin
    if ((pkt_if.valid && pkt_if.ready) || (evt_if.valid && evt_if.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: watchdog expired, no transaction for %0d cycles", $time, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result sink: random stalls, or a long hold-off on request
  initial begin
    evt_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_reqs) begin
        evt_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        holds_done <= holds_done + 1;
      end
      evt_if.ready <= steady || ($urandom_range(0, 99) >= 37);
    end
  end

  function automatic dpnm_pkg::in_item_t make_item(bit req, int cable, int status, int note,
                                                   int value, int chan);
    dpnm_pkg::in_item_t it;
    it.req_type      = req;
    it.cable_num     = 4'(cable);
    it.status_byte   = 8'(status);
    it.note_in       = 7'(note);
    it.value_in      = 7'(value);
    it.track_channel = 4'(chan);
    return it;
  endfunction

  // Mostly well-formed pad traffic, often on recently used pads so note-offs
  // and pressure find held pads and the running ratchet.
  function dpnm_pkg::in_item_t random_packet();
    dpnm_pkg::in_item_t        it;
    int                        pick;
    logic [dpnm_pkg::IdxW-1:0] pad;
    logic [7:0]                status;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      it = make_item(1'b1, $urandom_range(0, 15), $urandom_range(0, 255),
                     $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 15));
    end else if (pick < 14) begin
      it = make_item(1'b0, $urandom_range(0, 15), $urandom_range(0, 255),
                     $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 15));
    end else begin
      if ($urandom_range(0, 99) < 45) pad = recent_pads[$urandom_range(0, 3)];
      else pad = dpnm_pkg::IdxW'($urandom_range(0, dpnm_pkg::NumPads - 1));
      recent_pads[$urandom_range(0, 3)] = pad;
      pick = $urandom_range(0, 99);
      if (pick < 45) status = dpnm_pkg::StatusNoteOn;
      else if (pick < 80) status = dpnm_pkg::StatusNoteOff;
      else status = dpnm_pkg::StatusPressure;
      status = status | 8'($urandom_range(0, 15));
      it = make_item(1'b0, 0, status, int'(dpnm_pkg::PadLow) + int'(pad),
                     ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 127),
                     $urandom_range(0, 15));
    end
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input dpnm_pkg::in_item_t it);
    if (!steady && $urandom_range(0, 99) < 37) begin
      pkt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    pkt_if.valid <= 1'b1;
    pkt_if.data  <= it;
    do @(posedge clk); while (!pkt_if.ready);
    @(negedge clk);
  endtask

  task automatic run_items(input int count);
    for (int i = 0; i < count; i++) send_item(random_packet());
  endtask

  task automatic settle();
    pkt_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input dpnm_pkg::cfg_reg_e which, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= dpnm_pkg::PaddrW'(4 * int'(which));
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(which, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [31:0] mode, input logic [31:0] base,
                           input logic [31:0] fixed);
    write_reg(dpnm_pkg::RegPadMode, mode);
    write_reg(dpnm_pkg::RegBaseNote, base);
    write_reg(dpnm_pkg::RegFixedVel, fixed);
  endtask

  initial begin
    rst_n        = 1'b0;
    pkt_if.valid = 1'b0;
    pkt_if.data  = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    foreach (recent_pads[i]) recent_pads[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // drum mode at reset settings: range ends, ignored packets, held note-offs
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOn, dpnm_pkg::PadLow, 127, 15));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOff | 8'h0F, dpnm_pkg::PadLow, 64, 3));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOn | 8'h0F, dpnm_pkg::PadHigh, 1, 0));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOn, dpnm_pkg::PadHigh, 0, 5));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOff, dpnm_pkg::PadLow + 2, 0, 0));
    send_item(make_item(1'b0, 15, dpnm_pkg::StatusNoteOn, dpnm_pkg::PadLow + 2, 90, 1));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOn, dpnm_pkg::PadLow - 1, 90, 1));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOn, dpnm_pkg::PadHigh + 1, 90, 1));
    send_item(make_item(1'b0, 0, 8'hB0, dpnm_pkg::PadLow + 2, 90, 1));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusPressure, dpnm_pkg::PadLow, 50, 1));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOn, dpnm_pkg::PadLow + 7, 70, 9));
    send_item(make_item(1'b1, 0, 0, 0, 0, 0));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOff, dpnm_pkg::PadLow + 7, 0, 9));

    // ratchet pads: start, pressure, restart, stop, all notes off
    settle();
    configure(dpnm_pkg::ModeRatchet, 36, 0);
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOn, dpnm_pkg::PadLow + 1, 80, 4));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOn, dpnm_pkg::PadLow + 4, 90, 2));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusPressure, dpnm_pkg::PadLow + 4, 0, 2));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusPressure, dpnm_pkg::PadLow + 5, 60, 2));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOn, dpnm_pkg::PadHigh, 127, 11));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOff, dpnm_pkg::PadLow + 4, 0, 2));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOff, dpnm_pkg::PadHigh, 0, 11));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOn, dpnm_pkg::PadLow + 8 + 4, 33, 6));
    send_item(make_item(1'b1, 0, 0, 0, 0, 0));

    // velocity pads, with the cap and with fixed velocity
    settle();
    configure(dpnm_pkg::ModeVelocity, 36, 0);
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOn, dpnm_pkg::PadHigh, 10, 7));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOn, dpnm_pkg::PadLow + 4, 10, 7));
    settle();
    configure(dpnm_pkg::ModeVelocity, 36, 1);
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOn, dpnm_pkg::PadLow + 4, 10, 7));
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOn, dpnm_pkg::PadLow, 10, 7));

    // out-of-range mode and base: top pad plays note 127
    settle();
    configure(3, 127, 0);
    send_item(make_item(1'b0, 0, dpnm_pkg::StatusNoteOn, dpnm_pkg::PadHigh, 55, 12));

    settle();
    configure(dpnm_pkg::ModeDrums, 0, 0);
    run_items(100);

    settle();
    configure(dpnm_pkg::ModeRatchet, dpnm_pkg::BaseNoteMax, 1);
    run_items(100);

    settle();
    configure(dpnm_pkg::ModeVelocity, 36, 0);
    steady <= 1'b1;
    run_items(100);
    settle();
    steady <= 1'b0;

    // sink holds off while packets keep coming, then the source drains mid-phase
    configure(dpnm_pkg::ModeRatchet, 60, 0);
    hold_reqs <= hold_reqs + 1;
    run_items(50);
    settle();
    run_items(50);

    settle();
    configure(3, 127, 1);
    run_items(100);

    settle();
    configure($urandom(), $urandom(), $urandom());
    run_items(100);

    settle();
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== drum_pad_note_mapper.f =====
design/dpnm_pkg.sv
design/dpnm_in_if.sv
design/dpnm_out_if.sv
design/dpnm_evt_fifo.sv
design/drum_pad_note_mapper.sv
tb/sv/testbench.sv
